@@ hdl/stpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stpq_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEFAULT    = 64;
  localparam int OVERHEAD_DEFAULT = 104;

  // Field widths fixed by the interface
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 24;
  localparam int DUR_W    = 32;
  localparam int STREAM_W = 8;
  localparam int SERIAL_W = 32;
  localparam int COUNT_W  = 7;
  localparam int BYTES_W  = 31;
  localparam int TIME_W   = 38;

  // Command codes
  typedef enum logic [2:0] {
    FUNC_PUT        = 3'd0,
    FUNC_PUT_MARKER = 3'd1,
    FUNC_GET        = 3'd2,
    FUNC_ABORT      = 3'd3,
    FUNC_START      = 3'd4,
    FUNC_FLUSH      = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABORTED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // One queue slot
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    duration;
    logic [STREAM_W-1:0] stream;
    logic [SERIAL_W-1:0] serial;
    logic                marker;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch payload and read the head slot
    logic exec;       // update result registers
    logic push;       // store an entry at the tail
    logic marker;     // the pushed entry is a flush marker
    logic pop;        // remove the head entry
    logic set_abort;
    logic clr_abort;
    logic flush;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic aborted;
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/stpq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stpq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        func,
  input  wire stpq_pkg::dp_stat_t stat,
  output stpq_pkg::dp_cmd_t      cmd,
  output logic                   busy,
  output logic                   done,
  output logic [1:0]             status
);
  import stpq_pkg::*;

  state_t  state, state_next;
  func_t   func_q;
  status_t status_next;

  // State register, latched command, result strobe and status
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
    if (cmd.capture) begin
      func_q <= func_t'(func);
    end
    if (cmd.exec) begin
      status <= status_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next  = state;
    cmd         = '0;
    status_next = ST_OK;
    busy        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
        case (func_q)
          FUNC_PUT, FUNC_PUT_MARKER: begin
            if (stat.aborted) begin
              status_next = ST_ABORTED;
            end else if (stat.full) begin
              status_next = ST_FULL;
            end else begin
              cmd.push   = 1'b1;
              cmd.marker = (func_q == FUNC_PUT_MARKER);
            end
          end
          FUNC_GET: begin
            if (stat.aborted) begin
              status_next = ST_ABORTED;
            end else if (stat.empty) begin
              status_next = ST_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          FUNC_ABORT: cmd.set_abort = 1'b1;
          FUNC_START: begin
            // abort clears even when the marker is refused
            cmd.clr_abort = 1'b1;
            if (stat.full) begin
              status_next = ST_FULL;
            end else begin
              cmd.push   = 1'b1;
              cmd.marker = 1'b1;
            end
          end
          FUNC_FLUSH: cmd.flush = 1'b1;
          default: ;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> done) else $error("no result strobe after execute");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop)) else $error("push and pop in one step");
`endif

endmodule

`default_nettype wire

@@ hdl/stpq_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stpq_dp #(
  parameter int DEPTH          = stpq_pkg::DEPTH_DEFAULT,
  parameter int ENTRY_OVERHEAD = stpq_pkg::OVERHEAD_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stpq_pkg::dp_cmd_t             cmd,
  output stpq_pkg::dp_stat_t                 stat,
  input  wire logic [stpq_pkg::HANDLE_W-1:0] pkt_handle,
  input  wire logic [stpq_pkg::SIZE_W-1:0]   pkt_size,
  input  wire logic [stpq_pkg::DUR_W-1:0]    pkt_duration,
  input  wire logic [stpq_pkg::STREAM_W-1:0] pkt_stream,
  output logic [stpq_pkg::HANDLE_W-1:0]      out_handle,
  output logic [stpq_pkg::SIZE_W-1:0]        out_size,
  output logic [stpq_pkg::DUR_W-1:0]         out_duration,
  output logic [stpq_pkg::STREAM_W-1:0]      out_stream,
  output logic [stpq_pkg::SERIAL_W-1:0]      out_serial,
  output logic                               out_is_marker,
  output logic [stpq_pkg::COUNT_W-1:0]       entry_count,
  output logic [stpq_pkg::BYTES_W-1:0]       byte_total,
  output logic [stpq_pkg::TIME_W-1:0]        duration_total,
  output logic [stpq_pkg::SERIAL_W-1:0]      serial_now,
  output logic                               abort_flag
);
  import stpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]      LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0]      FULL_CNT  = CW'(DEPTH);
  localparam logic [BYTES_W-1:0] OVERHEAD  = BYTES_W'(ENTRY_OVERHEAD);

  entry_t mem [DEPTH];
  entry_t rd_entry;
  entry_t wr_entry;

  logic [AW-1:0]       head, tail;
  logic [CW-1:0]       count;
  logic [BYTES_W-1:0]  bytes;
  logic [TIME_W-1:0]   total_time;
  logic [SERIAL_W-1:0] serial;
  logic                aborted;

  logic [HANDLE_W-1:0] handle_q;
  logic [SIZE_W-1:0]   size_q;
  logic [DUR_W-1:0]    dur_q;
  logic [STREAM_W-1:0] stream_q;

  logic [SERIAL_W-1:0] serial_inc;
  logic [AW-1:0]       head_inc, tail_inc;

  assign serial_inc = serial + 1'b1;
  assign head_inc   = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_inc   = (tail == LAST_SLOT) ? '0 : tail + 1'b1;

  assign stat.aborted = aborted;
  assign stat.empty   = (count == '0);
  assign stat.full    = (count >= FULL_CNT);

  // Entry written at the tail; a marker carries zeros and the new serial
  always_comb begin
    if (cmd.marker) begin
      wr_entry        = '0;
      wr_entry.serial = serial_inc;
      wr_entry.marker = 1'b1;
    end else begin
      wr_entry.handle   = handle_q;
      wr_entry.size     = size_q;
      wr_entry.duration = dur_q;
      wr_entry.stream   = stream_q;
      wr_entry.serial   = serial;
      wr_entry.marker   = 1'b0;
    end
  end

  // Slot memory: written at the tail, head read when a request is taken
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= wr_entry;
    end
    if (cmd.capture) begin
      rd_entry <= mem[head];
    end
  end

  // Request payload latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      handle_q <= pkt_handle;
      size_q   <= pkt_size;
      dur_q    <= pkt_duration;
      stream_q <= pkt_stream;
    end
  end

  // Pointers, totals, serial and abort state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      bytes      <= '0;
      total_time <= '0;
      serial     <= '0;
      aborted    <= 1'b1;
    end else begin
      if (cmd.set_abort) aborted <= 1'b1;
      if (cmd.clr_abort) aborted <= 1'b0;
      priority if (cmd.flush) begin
        head       <= '0;
        tail       <= '0;
        count      <= '0;
        bytes      <= '0;
        total_time <= '0;
      end else if (cmd.push) begin
        tail       <= tail_inc;
        count      <= count + 1'b1;
        bytes      <= bytes + BYTES_W'(wr_entry.size) + OVERHEAD;
        total_time <= total_time + TIME_W'(wr_entry.duration);
        if (cmd.marker) serial <= serial_inc;
      end else if (cmd.pop) begin
        head       <= head_inc;
        count      <= count - 1'b1;
        bytes      <= bytes - BYTES_W'(rd_entry.size) - OVERHEAD;
        total_time <= total_time - TIME_W'(rd_entry.duration);
      end else begin
        // pointers and totals hold
      end
    end
  end

  // Dequeued fields, zero unless a get returns an entry
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (cmd.pop) begin
        out_handle    <= rd_entry.handle;
        out_size      <= rd_entry.size;
        out_duration  <= rd_entry.duration;
        out_stream    <= rd_entry.stream;
        out_serial    <= rd_entry.serial;
        out_is_marker <= rd_entry.marker;
      end else begin
        out_handle    <= '0;
        out_size      <= '0;
        out_duration  <= '0;
        out_stream    <= '0;
        out_serial    <= '0;
        out_is_marker <= 1'b0;
      end
    end
  end

  assign entry_count    = COUNT_W'(count);
  assign byte_total     = bytes;
  assign duration_total = total_time;
  assign serial_now     = serial;
  assign abort_flag     = aborted;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("entry count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0) else $error("pop from empty queue");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> count == '0 && bytes == '0 && total_time == '0)
    else $error("flush left entries or totals");
`endif

endmodule

`default_nettype wire

@@ hdl/serial_tagged_packet_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A request taken while idle is latched, with the head slot read from the memory's registered
//   port; the execute step then does the pointer and total updates, and done, registered from
//   it, strobes the result. No new request is taken while busy in the execute step.
// The receiver cannot stall: done is a one-cycle strobe; results hold until the next execute.
// Reset (rst, synchronous): queue empty, totals and serial zero, queue in aborted state.
module serial_tagged_packet_queue #(
  parameter int DEPTH          = stpq_pkg::DEPTH_DEFAULT,
  parameter int ENTRY_OVERHEAD = stpq_pkg::OVERHEAD_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    func,
  input  wire logic [stpq_pkg::HANDLE_W-1:0] pkt_handle,
  input  wire logic [stpq_pkg::SIZE_W-1:0]   pkt_size,
  input  wire logic [stpq_pkg::DUR_W-1:0]    pkt_duration,
  input  wire logic [stpq_pkg::STREAM_W-1:0] pkt_stream,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [stpq_pkg::HANDLE_W-1:0]      out_handle,
  output logic [stpq_pkg::SIZE_W-1:0]        out_size,
  output logic [stpq_pkg::DUR_W-1:0]         out_duration,
  output logic [stpq_pkg::STREAM_W-1:0]      out_stream,
  output logic [stpq_pkg::SERIAL_W-1:0]      out_serial,
  output logic                               out_is_marker,
  output logic [stpq_pkg::COUNT_W-1:0]       entry_count,
  output logic [stpq_pkg::BYTES_W-1:0]       byte_total,
  output logic [stpq_pkg::TIME_W-1:0]        duration_total,
  output logic [stpq_pkg::SERIAL_W-1:0]      serial_now,
  output logic                               abort_flag
);
  import stpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  stpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  // Slot memory, pointers and totals
  stpq_dp #(
    .DEPTH          (DEPTH),
    .ENTRY_OVERHEAD (ENTRY_OVERHEAD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .pkt_handle     (pkt_handle),
    .pkt_size       (pkt_size),
    .pkt_duration   (pkt_duration),
    .pkt_stream     (pkt_stream),
    .out_handle     (out_handle),
    .out_size       (out_size),
    .out_duration   (out_duration),
    .out_stream     (out_stream),
    .out_serial     (out_serial),
    .out_is_marker  (out_is_marker),
    .entry_count    (entry_count),
    .byte_total     (byte_total),
    .duration_total (duration_total),
    .serial_now     (serial_now),
    .abort_flag     (abort_flag)
  );

endmodule

`default_nettype wire

@@ bench/serial_tagged_packet_queue_tb.sv @@
`timescale 1ns / 1ps

module serial_tagged_packet_queue_tb;
  import stpq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int OVERHEAD    = OVERHEAD_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 600;

  // Command codes the block treats as no-ops
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]          func;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    duration;
    logic [STREAM_W-1:0] stream;
  } queue_req_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    duration;
    logic [STREAM_W-1:0] stream;
    logic [SERIAL_W-1:0] serial;
    logic                marker;
    logic [COUNT_W-1:0]  count;
    logic [BYTES_W-1:0]  bytes;
    logic [TIME_W-1:0]   dur_total;
    logic [SERIAL_W-1:0] serial_now;
    logic                aborted;
  } queue_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          func = 3'd0;
  logic [HANDLE_W-1:0] pkt_handle = '0;
  logic [SIZE_W-1:0]   pkt_size = '0;
  logic [DUR_W-1:0]    pkt_duration = '0;
  logic [STREAM_W-1:0] pkt_stream = '0;
  logic                done;
  logic [1:0]          status;
  logic [HANDLE_W-1:0] out_handle;
  logic [SIZE_W-1:0]   out_size;
  logic [DUR_W-1:0]    out_duration;
  logic [STREAM_W-1:0] out_stream;
  logic [SERIAL_W-1:0] out_serial;
  logic                out_is_marker;
  logic [COUNT_W-1:0]  entry_count;
  logic [BYTES_W-1:0]  byte_total;
  logic [TIME_W-1:0]   duration_total;
  logic [SERIAL_W-1:0] serial_now;
  logic                abort_flag;

  serial_tagged_packet_queue #(
    .DEPTH          (DEPTH),
    .ENTRY_OVERHEAD (OVERHEAD)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .pkt_handle     (pkt_handle),
    .pkt_size       (pkt_size),
    .pkt_duration   (pkt_duration),
    .pkt_stream     (pkt_stream),
    .done           (done),
    .status         (status),
    .out_handle     (out_handle),
    .out_size       (out_size),
    .out_duration   (out_duration),
    .out_stream     (out_stream),
    .out_serial     (out_serial),
    .out_is_marker  (out_is_marker),
    .entry_count    (entry_count),
    .byte_total     (byte_total),
    .duration_total (duration_total),
    .serial_now     (serial_now),
    .abort_flag     (abort_flag)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the queue
  entry_t              slots[DEPTH];
  int                  head_idx = 0;
  int                  tail_idx = 0;
  int                  held = 0;
  logic [BYTES_W-1:0]  bytes_q = '0;
  logic [TIME_W-1:0]   dur_sum_q = '0;
  logic [SERIAL_W-1:0] serial_q = '0;
  logic                aborted_q = 1'b1;

  queue_req_t    pending_reqs[$];
  queue_result_t expected_results[$];
  queue_req_t    next_req;
  queue_result_t oldest;
  int            queued_count = 0;
  int            accepted_count = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            burst_left = 1;
  int            gap_left = 0;
  logic          taken = 1'b0;

  // Append at the tail unless full; a marker bumps the serial first
  function automatic status_t store_entry(entry_t e);
    if (held >= DEPTH) return ST_FULL;
    if (e.marker) serial_q = serial_q + 1'b1;
    e.serial = serial_q;
    slots[tail_idx] = e;
    tail_idx = (tail_idx + 1) % DEPTH;
    held++;
    bytes_q = BYTES_W'(bytes_q + e.size + OVERHEAD);
    dur_sum_q = dur_sum_q + e.duration;
    return ST_OK;
  endfunction

  function automatic queue_result_t apply_request(queue_req_t req);
    queue_result_t r;
    entry_t e;
    r = '0;
    e = '0;
    r.status = ST_OK;
    case (req.func)
      FUNC_PUT, FUNC_PUT_MARKER: begin
        if (aborted_q) begin
          r.status = ST_ABORTED;
        end else if (req.func == FUNC_PUT) begin
          e.handle = req.handle;
          e.size = req.size;
          e.duration = req.duration;
          e.stream = req.stream;
          r.status = store_entry(e);
        end else begin
          e.marker = 1'b1;
          r.status = store_entry(e);
        end
      end
      FUNC_GET: begin
        if (aborted_q) begin
          r.status = ST_ABORTED;
        end else if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = slots[head_idx];
          r.handle = e.handle;
          r.size = e.size;
          r.duration = e.duration;
          r.stream = e.stream;
          r.serial = e.serial;
          r.marker = e.marker;
          bytes_q = BYTES_W'(bytes_q - e.size - OVERHEAD);
          dur_sum_q = dur_sum_q - e.duration;
          held--;
          head_idx = (head_idx + 1) % DEPTH;
        end
      end
      FUNC_ABORT: aborted_q = 1'b1;
      FUNC_START: begin
        aborted_q = 1'b0;
        e.marker = 1'b1;
        r.status = store_entry(e);
      end
      FUNC_FLUSH: begin
        head_idx = 0;
        tail_idx = 0;
        held = 0;
        bytes_q = '0;
        dur_sum_q = '0;
      end
      default: ;
    endcase
    r.count = held[COUNT_W-1:0];
    r.bytes = bytes_q;
    r.dur_total = dur_sum_q;
    r.serial_now = serial_q;
    r.aborted = aborted_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Monitor: check results, predict each accepted request
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      taken <= start && !busy;
      if (!rst) begin
        if (done) begin
          if (expected_results.size() == 0) begin
            $error("result with no request outstanding");
            mismatch_count++;
          end else begin
            oldest = expected_results.pop_front();
            check_field("status", oldest.status, status);
            check_field("out_handle", oldest.handle, out_handle);
            check_field("out_size", oldest.size, out_size);
            check_field("out_duration", oldest.duration, out_duration);
            check_field("out_stream", oldest.stream, out_stream);
            check_field("out_serial", oldest.serial, out_serial);
            check_field("out_is_marker", oldest.marker, out_is_marker);
            check_field("entry_count", oldest.count, entry_count);
            check_field("byte_total", oldest.bytes, byte_total);
            check_field("duration_total", oldest.dur_total, duration_total);
            check_field("serial_now", oldest.serial_now, serial_now);
            check_field("abort_flag", oldest.aborted, abort_flag);
          end
        end
        if (start && !busy) begin
          expected_results.push_back(apply_request(
            '{func, pkt_handle, pkt_size, pkt_duration, pkt_stream}));
          accepted_count++;
        end
      end
    end
  end

  // Driver: hold a request until taken, then send the next in bursts with gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        func <= next_req.func;
        pkt_handle <= next_req.handle;
        pkt_size <= next_req.size;
        pkt_duration <= next_req.duration;
        pkt_stream <= next_req.stream;
        start <= 1'b1;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(1, 5);
          end
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_req(logic [2:0] f, logic [31:0] h, logic [23:0] s, logic [31:0] d,
                         logic [7:0] st);
    pending_reqs.push_back('{f, h, s, d, st});
    queued_count++;
  endtask

  // Zero, all ones, or random, at the given width
  function automatic logic [31:0] pick_value(int bits);
    logic [31:0] mask;
    mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'h1 << bits) - 1);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  task automatic add_random_req(logic [2:0] f);
    add_req(f, pick_value(HANDLE_W), SIZE_W'(pick_value(SIZE_W)), pick_value(DUR_W),
            STREAM_W'(pick_value(STREAM_W)));
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int random_count;
    int roll;
    int n;
    bit paused;
    bit saturate;
    logic [2:0] f;

    random_count = 0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Aborted after reset: put, marker and get are refused
    add_req(FUNC_PUT, '1, '1, '1, '1);
    add_req(FUNC_GET, '0, '0, '0, '0);
    add_req(FUNC_PUT_MARKER, '0, '0, '0, '0);
    add_req(FUNC_SPARE_6, '1, '1, '1, '1);
    add_req(FUNC_SPARE_7, '0, '0, '0, '0);
    // Start enqueues a marker, then field extremes go through
    add_req(FUNC_START, '0, '0, '0, '0);
    add_req(FUNC_PUT, '0, '0, '0, '0);
    add_req(FUNC_PUT, '1, '1, '1, '1);
    add_req(FUNC_PUT, 32'hA5A5_5A5A, 24'h5A_A55A, 32'h5A5A_A5A5, 8'hA5);
    add_req(FUNC_PUT_MARKER, '1, '1, '1, '1);
    repeat (5) add_req(FUNC_GET, '0, '0, '0, '0);
    // Empty get
    add_req(FUNC_GET, '1, '1, '1, '1);
    // Abort keeps the contents; flush works while aborted
    add_req(FUNC_PUT, 32'h1234_5678, 24'h00_0100, 32'h0000_1000, 8'h01);
    add_req(FUNC_ABORT, '0, '0, '0, '0);
    add_req(FUNC_GET, '0, '0, '0, '0);
    add_req(FUNC_PUT, '1, '1, '1, '1);
    add_req(FUNC_FLUSH, '0, '0, '0, '0);
    add_req(FUNC_START, '0, '0, '0, '0);
    add_req(FUNC_GET, '0, '0, '0, '0);
    add_req(FUNC_FLUSH, '0, '0, '0, '0);
    add_req(FUNC_GET, '0, '0, '0, '0);
    wait_drained();

    // Random episodes: fill to full, drain past empty, or a weighted mix
    roll = 0;
    while (random_count < RANDOM_REQS) begin
      if (!paused && random_count >= RANDOM_REQS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if (roll == 0) begin
        // Fill; saturated fills drive the totals to their largest values
        saturate = (random_count == 0) || ($urandom_range(0, 3) == 0);
        add_random_req(FUNC_START);
        for (int i = 0; i < DEPTH + 2; i++) begin
          if (saturate)
            add_req(FUNC_PUT, '1, '1, '1, '1);
          else
            add_random_req(($urandom_range(0, 7) == 0) ? FUNC_PUT_MARKER : FUNC_PUT);
        end
        add_random_req(FUNC_START);
        add_random_req(FUNC_PUT_MARKER);
        random_count += DEPTH + 5;
      end else if (roll == 1) begin
        // Drain, occasionally after an abort
        if ($urandom_range(0, 4) == 0) add_random_req(FUNC_ABORT);
        n = DEPTH + 2;
        repeat (n) add_random_req(FUNC_GET);
        random_count += n;
      end else begin
        n = $urandom_range(10, 40);
        for (int i = 0; i < n; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 38) f = FUNC_PUT;
          else if (roll < 46) f = FUNC_PUT_MARKER;
          else if (roll < 80) f = FUNC_GET;
          else if (roll < 83) f = FUNC_ABORT;
          else if (roll < 88) f = FUNC_START;
          else if (roll < 93) f = FUNC_FLUSH;
          else if (roll < 96) f = FUNC_SPARE_6;
          else f = FUNC_SPARE_7;
          add_random_req(f);
          if (f != FUNC_SPARE_6 && f != FUNC_SPARE_7) random_count++;
        end
      end
      roll = $urandom_range(0, 5);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
